/* rtl/clsrng_pkg.sv */
// Shared types and constants for the combined LCG shuffle random number core.
// No dependencies; used by the core, its table RAM hookup and the port checker.
`timescale 1ns / 1ps

package clsrng_pkg;

    // Shuffle table geometry
    localparam int TABLE_SIZE = 32;
    localparam int TAB_AW     = $clog2(TABLE_SIZE);
    // Reinit runs TABLE_SIZE + 8 steps; counter counts down from TABLE_SIZE + 7
    localparam int INIT_STEPS = TABLE_SIZE + 8;
    localparam int CNT_W      = $clog2(INIT_STEPS);

    localparam int GEN_W = 32;
    // Quotient bound: |x| / 52774 < 2^16, and the slot quotient stays at or below 32
    localparam int QUO_W = 16;

    // Restoring divider for the bounded result
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Generator constants (Schrage factorization m = a * q + r)
    localparam logic [31:0] MOD_ONE = 32'd2147483563;
    localparam logic [31:0] MOD_TWO = 32'd2147483399;
    localparam logic [31:0] MUL_ONE = 32'd40014;
    localparam logic [31:0] MUL_TWO = 32'd40692;
    localparam logic [31:0] QUO_ONE = 32'd53668;
    localparam logic [31:0] QUO_TWO = 32'd52774;
    localparam logic [31:0] REM_ONE = 32'd12211;
    localparam logic [31:0] REM_TWO = 32'd3791;

    localparam logic [31:0] SPAN     = MOD_ONE - 32'd1;
    localparam logic [31:0] SLOT_DIV = 32'd1 + (SPAN / 32'(TABLE_SIZE));

    // Reciprocal constants: floor(2^SH / d), with SH = 31 + clog2(d) so it fits 32 bits.
    // The estimate is at most one below the true quotient.
    localparam logic [63:0] ONE64     = 64'd1;
    localparam int          SH_ONE    = 31 + $clog2(QUO_ONE);
    localparam int          SH_TWO    = 31 + $clog2(QUO_TWO);
    localparam int          SH_SLOT   = 31 + $clog2(SLOT_DIV);
    localparam logic [31:0] RCP_ONE   = 32'((ONE64 << SH_ONE) / {32'd0, QUO_ONE});
    localparam logic [31:0] RCP_TWO   = 32'((ONE64 << SH_TWO) / {32'd0, QUO_TWO});
    localparam logic [31:0] RCP_SLOT  = 32'((ONE64 << SH_SLOT) / {32'd0, SLOT_DIV});

    // Operation codes
    localparam logic OP_DRAW     = 1'b0;
    localparam logic OP_MODULATE = 1'b1;

    // Which value the shared multiply sequence is working on
    typedef enum logic [1:0] {
        JOB_G1   = 2'd0,
        JOB_G2   = 2'd1,
        JOB_SLOT = 2'd2
    } job_t;

    typedef struct packed {
        logic               operation;
        logic        [31:0] modulus;
        logic signed [31:0] modulate_amount;
    } item_t;

    typedef struct packed {
        logic [30:0] random_value;
        logic [31:0] bounded_value;
        logic        random_bit;
    } result_t;

endpackage

/* rtl/combined_lcg_shuffle_rng_core.sv */
// Combined two-generator LCG with Bays-Durham shuffle table, one shared multiplier.
// Depends on clsrng_pkg and clsrng_ram.
`timescale 1ns / 1ps

//  channel  | signals                          | moves
//  ---------+----------------------------------+---------------------------------------
//  item     | item_valid, item_ready, item     | operation, modulus, modulate_amount
//  result   | result_valid, result_ready, result | random_value, bounded_value, random_bit
//  cfg      | cfg_valid, cfg_ready, cfg_data   | seed (31 bits)
//
//  One 32x32 multiplier serves four products in each generator step and two in the
//  slot divide, then a restoring divider gives the bounded result at one bit per
//  cycle. A reinitializing draw adds 40 steps of generator one. A modulate item runs
//  two combined steps without the divider, plus any reinit. item_ready and cfg_ready
//  are high only when idle; a held result stalls the core before it loads the next
//  one. Reset is async, active low, on the control registers only.

module combined_lcg_shuffle_rng_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  clsrng_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output clsrng_pkg::result_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [30:0]         cfg_data
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_CHECK = 12'b0000_0000_0010,
        ST_DV0   = 12'b0000_0000_0100,
        ST_DV1   = 12'b0000_0000_1000,
        ST_DV2   = 12'b0000_0001_0000,
        ST_SC0   = 12'b0000_0010_0000,
        ST_SC1   = 12'b0000_0100_0000,
        ST_SC2   = 12'b0000_1000_0000,
        ST_RD    = 12'b0001_0000_0000,
        ST_MIX   = 12'b0010_0000_0000,
        ST_DIV   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } state_t;

    // Control state
    state_t                       state_reg, state_next;
    clsrng_pkg::job_t             job_reg, job_next;
    logic                         reinit_reg, reinit_next;
    logic                         phase_reg, phase_next;
    logic [clsrng_pkg::CNT_W-1:0] n_reg, n_next;
    logic                         out_valid_reg, out_valid_next;
    logic [31:0]                  g1_reg, g1_next;
    logic [31:0]                  g2_reg, g2_next;
    logic [31:0]                  sout_reg, sout_next;

    // Datapath registers
    logic                                  op_reg, op_next;
    logic [31:0]                           mod_reg, mod_next;
    logic [31:0]                           amt_reg, amt_next;
    logic [63:0]                           prod_reg, prod_next;
    logic [clsrng_pkg::QUO_W-1:0]          quo_reg, quo_next;
    logic [clsrng_pkg::QUO_W-1:0]          urem_reg, urem_next;
    logic [31:0]                           t_reg, t_next;
    logic [clsrng_pkg::TAB_AW-1:0]         slot_reg, slot_next;
    logic [31:0]                           rem_reg, rem_next;
    logic [31:0]                           dvd_reg, dvd_next;
    logic [clsrng_pkg::DIV_CNT_W-1:0]      dcnt_reg, dcnt_next;
    clsrng_pkg::result_t                   res_reg, res_next;

    // Shared multiplier operands
    logic [31:0] mul_a;
    logic [31:0] mul_b;

    // Per-job constants and source
    logic [31:0]                  c_rcp, c_div, c_mul, c_rem, c_mod, src;
    logic [clsrng_pkg::QUO_W-1:0] k_est;
    logic                         src_neg;
    logic [31:0]                  ax;

    // Table RAM hookup
    logic                          ram_we;
    logic [clsrng_pkg::TAB_AW-1:0] ram_waddr;
    logic [31:0]                   ram_wdata;
    logic                          ram_re;
    logic [31:0]                   ram_rdata;

    // Intermediate arithmetic
    logic [31:0]                   rem0;
    logic                          corr;
    logic [clsrng_pkg::QUO_W-1:0]  quo_fix;
    logic signed [33:0]            v_s, yv_s, yfix_s;
    logic signed [33:0]            pos_s, posfix_s;
    logic [31:0]                   g1_sub, g1_fix, g2_sub, g2_fix, cfg_g1;
    logic [32:0]                   div_shift, div_trial;

    clsrng_ram #(
        .WIDTH (clsrng_pkg::GEN_W),
        .DEPTH (clsrng_pkg::TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    assign item_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = res_reg;

    // Constant and source select per job, plus quotient estimate from the product
    always_comb
    begin
        case (job_reg)
            clsrng_pkg::JOB_G1:
            begin
                c_rcp = clsrng_pkg::RCP_ONE;
                c_div = clsrng_pkg::QUO_ONE;
                c_mul = clsrng_pkg::MUL_ONE;
                c_rem = clsrng_pkg::REM_ONE;
                c_mod = clsrng_pkg::MOD_ONE;
                src   = g1_reg;
                k_est = prod_reg[clsrng_pkg::SH_ONE +: clsrng_pkg::QUO_W];
            end
            clsrng_pkg::JOB_G2:
            begin
                c_rcp = clsrng_pkg::RCP_TWO;
                c_div = clsrng_pkg::QUO_TWO;
                c_mul = clsrng_pkg::MUL_TWO;
                c_rem = clsrng_pkg::REM_TWO;
                c_mod = clsrng_pkg::MOD_TWO;
                src   = g2_reg;
                k_est = prod_reg[clsrng_pkg::SH_TWO +: clsrng_pkg::QUO_W];
            end
            default:
            begin
                c_rcp = clsrng_pkg::RCP_SLOT;
                c_div = clsrng_pkg::SLOT_DIV;
                c_mul = '0;
                c_rem = '0;
                c_mod = '0;
                src   = sout_reg;
                // Slot quotient sits in the top bits of the product
                k_est = clsrng_pkg::QUO_W'(prod_reg[63:clsrng_pkg::SH_SLOT]);
            end
        endcase
    end

    assign src_neg = src[31];
    assign ax      = src_neg ? (32'd0 - src) : src;

    // Quotient correction: estimate is exact or one low
    assign rem0    = ax - prod_reg[31:0];
    assign corr    = (rem0 >= c_div);
    assign quo_fix = quo_reg + clsrng_pkg::QUO_W'(corr);

    // Schrage finish: sign * (a * rem - k * r), then fold negatives by m
    assign v_s    = $signed({2'b00, t_reg}) - $signed({2'b00, prod_reg[31:0]});
    assign yv_s   = src_neg ? -v_s : v_s;
    assign yfix_s = yv_s[33] ? (yv_s + $signed({2'b00, c_mod})) : yv_s;

    // Shuffle combine
    assign pos_s    = $signed({{2{ram_rdata[31]}}, ram_rdata})
                    - $signed({{2{g2_reg[31]}}, g2_reg});
    assign posfix_s = (pos_s < 34'sd1) ? (pos_s + $signed({2'b00, clsrng_pkg::SPAN})) : pos_s;

    // Modulate adjustments and seed load
    assign g1_sub = g1_reg - amt_reg;
    assign g1_fix = g1_sub[31] ? (g1_sub + clsrng_pkg::MOD_ONE) : g1_sub;
    assign g2_sub = g2_reg - item.modulate_amount;
    assign g2_fix = g2_sub[31] ? (g2_sub + clsrng_pkg::MOD_TWO) : g2_sub;
    assign cfg_g1 = (cfg_data == '0) ? 32'hFFFF_FFFF : (32'd0 - {1'b0, cfg_data});

    // Restoring divider step
    assign div_shift = {rem_reg, dvd_reg[31]};
    assign div_trial = div_shift - {1'b0, mod_reg};

    // Shared multiplier, registered
    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        reinit_next    = reinit_reg;
        phase_next     = phase_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        sout_next      = sout_reg;
        op_next        = op_reg;
        mod_next       = mod_reg;
        amt_next       = amt_reg;
        quo_next       = quo_reg;
        urem_next      = urem_reg;
        t_next         = t_reg;
        slot_next      = slot_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dcnt_next      = dcnt_reg;
        res_next       = res_reg;
        mul_a          = '0;
        mul_b          = '0;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = g1_reg;
        ram_re         = 1'b0;

        // Result transfer frees the output register
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    g1_next = cfg_g1;
                end
                if (item_valid)
                begin
                    op_next    = item.operation;
                    mod_next   = item.modulus;
                    amt_next   = item.modulate_amount;
                    phase_next = 1'b0;
                    if (item.operation == clsrng_pkg::OP_MODULATE)
                    begin
                        g2_next = g2_fix;
                    end
                    state_next = ST_CHECK;
                end
            end

            // Reinit when generator one is at or below zero
            ST_CHECK:
            begin
                if (g1_reg[31] || (g1_reg == '0))
                begin
                    g2_next     = g1_reg;
                    n_next      = clsrng_pkg::CNT_W'(clsrng_pkg::INIT_STEPS - 1);
                    reinit_next = 1'b1;
                    job_next    = clsrng_pkg::JOB_G1;
                end
                else
                begin
                    reinit_next = 1'b0;
                    job_next    = clsrng_pkg::JOB_SLOT;
                end
                state_next = ST_DV0;
            end

            // Divide by constant: reciprocal estimate
            ST_DV0:
            begin
                mul_a      = ax;
                mul_b      = c_rcp;
                state_next = ST_DV1;
            end

            // Back-multiply the estimate
            ST_DV1:
            begin
                mul_a      = {{(32 - clsrng_pkg::QUO_W){1'b0}}, k_est};
                mul_b      = c_div;
                quo_next   = k_est;
                state_next = ST_DV2;
            end

            // Correct quotient and remainder
            ST_DV2:
            begin
                quo_next  = quo_fix;
                urem_next = corr ? clsrng_pkg::QUO_W'(rem0 - c_div) : clsrng_pkg::QUO_W'(rem0);
                if (job_reg == clsrng_pkg::JOB_SLOT)
                begin
                    if (src_neg || (src == '0))
                    begin
                        slot_next = '0;
                    end
                    else if (quo_fix >= clsrng_pkg::QUO_W'(clsrng_pkg::TABLE_SIZE))
                    begin
                        slot_next = clsrng_pkg::TAB_AW'(clsrng_pkg::TABLE_SIZE - 1);
                    end
                    else
                    begin
                        slot_next = quo_fix[clsrng_pkg::TAB_AW-1:0];
                    end
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_SC0;
                end
            end

            ST_SC0:
            begin
                mul_a      = {{(32 - clsrng_pkg::QUO_W){1'b0}}, urem_reg};
                mul_b      = c_mul;
                state_next = ST_SC1;
            end

            ST_SC1:
            begin
                t_next     = prod_reg[31:0];
                mul_a      = {{(32 - clsrng_pkg::QUO_W){1'b0}}, quo_reg};
                mul_b      = c_rem;
                state_next = ST_SC2;
            end

            // Write back the stepped generator
            ST_SC2:
            begin
                if (job_reg == clsrng_pkg::JOB_G1)
                begin
                    g1_next = yfix_s[31:0];
                    if (reinit_reg)
                    begin
                        if (n_reg < clsrng_pkg::CNT_W'(clsrng_pkg::TABLE_SIZE))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = n_reg[clsrng_pkg::TAB_AW-1:0];
                            ram_wdata = yfix_s[31:0];
                        end
                        if (n_reg == '0)
                        begin
                            sout_next   = yfix_s[31:0];
                            reinit_next = 1'b0;
                            job_next    = clsrng_pkg::JOB_SLOT;
                        end
                        else
                        begin
                            n_next = n_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        job_next = clsrng_pkg::JOB_G2;
                    end
                    state_next = ST_DV0;
                end
                else
                begin
                    g2_next    = yfix_s[31:0];
                    state_next = ST_MIX;
                end
            end

            // Read the chosen table entry
            ST_RD:
            begin
                ram_re     = 1'b1;
                job_next   = clsrng_pkg::JOB_G1;
                state_next = ST_DV0;
            end

            // Combine, refill the slot, then finish or run the second modulate draw
            ST_MIX:
            begin
                ram_we    = 1'b1;
                sout_next = posfix_s[31:0];
                if (op_reg == clsrng_pkg::OP_DRAW)
                begin
                    dvd_next   = posfix_s[31:0];
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
                else if (!phase_reg)
                begin
                    g1_next    = g1_fix;
                    phase_next = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // One quotient bit per cycle
            ST_DIV:
            begin
                rem_next  = div_trial[32] ? div_shift[31:0] : div_trial[31:0];
                dvd_next  = {dvd_reg[30:0], 1'b0};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == clsrng_pkg::DIV_CNT_W'(clsrng_pkg::DIV_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end

            // Load result once the output register is free
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    res_next.random_value  = sout_reg[30:0];
                    res_next.bounded_value = (mod_reg == '0) ? 32'd0 : rem_reg;
                    res_next.random_bit    = sout_reg[0];
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= clsrng_pkg::JOB_G1;
            reinit_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            g1_reg        <= 32'hFFFF_FFFF;
            g2_reg        <= '0;
            sout_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            reinit_reg    <= reinit_next;
            phase_reg     <= phase_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            g1_reg        <= g1_next;
            g2_reg        <= g2_next;
            sout_reg      <= sout_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        mod_reg  <= mod_next;
        amt_reg  <= amt_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        urem_reg <= urem_next;
        t_reg    <= t_next;
        slot_reg <= slot_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dcnt_reg <= dcnt_next;
        res_reg  <= res_next;
    end

endmodule

/* rtl/clsrng_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the shuffle table of the random number core.
`timescale 1ns / 1ps

module clsrng_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/clsrng_checker.sv */
// Port-level checks for the combined LCG shuffle random number core, bound to it.
// Depends on clsrng_pkg and combined_lcg_shuffle_rng_core.
`timescale 1ns / 1ps

module clsrng_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input clsrng_pkg::result_t result
);

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // Shuffled output never reads zero
    a_value_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.random_value != '0))
        else $error("random_value is zero");

    // Bit output tracks the raw value
    a_bit_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.random_bit == result.random_value[0]))
        else $error("random_bit differs from random_value low bit");

    // One item at a time: busy after each transfer
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item_ready high right after an item transfer");

endmodule

bind combined_lcg_shuffle_rng_core clsrng_checker u_clsrng_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for combined_lcg_shuffle_rng_core: directed table, then random phases
// under several seeds and idle patterns, results compared with an in-bench generator model.
// Depends on clsrng_pkg and the core RTL.

module tb_top;
    import clsrng_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int STALL_LIMIT   = 5000;
    // Covers a modulate whose two draws both reseed the table
    localparam int SETTLE_CYCLES = 700;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 125;
    localparam int NUM_PHASES    = 8;

    localparam longint G1_MOD   = longint'(MOD_ONE);
    localparam longint G1_MUL   = longint'(MUL_ONE);
    localparam longint G1_QUO   = longint'(QUO_ONE);
    localparam longint G1_REM   = longint'(REM_ONE);
    localparam longint G2_MOD   = longint'(MOD_TWO);
    localparam longint G2_MUL   = longint'(MUL_TWO);
    localparam longint G2_QUO   = longint'(QUO_TWO);
    localparam longint G2_REM   = longint'(REM_TWO);
    localparam longint G_SPAN   = longint'(SPAN);
    localparam longint SLOT_DEN = longint'(SLOT_DIV);

    typedef enum logic [2:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH,
        IDLE_PRESSURE
    } idle_mode_t;

    // Which expected fields a directed row types in by hand
    localparam logic [1:0] PIN_NONE    = 2'd0;
    localparam logic [1:0] PIN_BOUNDED = 2'd1;
    localparam logic [1:0] PIN_ALL     = 2'd2;

    typedef struct packed {
        logic        op;
        logic [31:0] modulus;
        logic [31:0] amount;
        logic [1:0]  pin;
        logic [30:0] pin_value;
        logic [31:0] pin_bounded;
        logic        aim_zero;
    } step_row_t;

    localparam int DIR_ROWS = 22;

    // Directed stimulus; aim_zero picks the amount that parks generator one at zero
    step_row_t dir_rows [DIR_ROWS] = '{
        '{OP_DRAW,     32'd0,          32'd0,          PIN_BOUNDED, 31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'd1,          32'd0,          PIN_BOUNDED, 31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'd2,          32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'hFFFFFFFF,   32'hFFFFFFFF,   PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'h80000000,   32'h80000000,   PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'h7FFFFFFF,   32'h7FFFFFFF,   PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_MODULATE, 32'hFFFFFFFF,   32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'd10,         32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_MODULATE, 32'd0,          32'h7FFFFFFF,   PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'd0,          32'h12345678,   PIN_BOUNDED, 31'd0,          32'd0,   1'b0},
        '{OP_MODULATE, 32'h55555555,   32'h80000000,   PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'd3,          32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_MODULATE, 32'hAAAAAAAA,   32'hFFFFFFFF,   PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'd1000,       32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_MODULATE, 32'd7,          32'd1,          PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'd5,          32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_MODULATE, 32'd0,          32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b1},
        '{OP_DRAW,     32'd0,          32'd0,          PIN_ALL,     31'd2147483562, 32'd0,   1'b0},
        '{OP_DRAW,     32'd1000,       32'd0,          PIN_ALL,     31'd2147483562, 32'd562, 1'b0},
        '{OP_MODULATE, 32'd0,          32'h80000001,   PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'hFFFFFFFF,   32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b0},
        '{OP_DRAW,     32'd7,          32'd0,          PIN_NONE,    31'd0,          32'd0,   1'b0}
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data     = '0;

    idle_mode_t  idle_mode    = IDLE_NONE;
    int          mismatches   = 0;

    // Generator model state
    int          gen_one;
    int          gen_two;
    int          shuf_out;
    int          shuf_tab [TABLE_SIZE];
    result_t     pending_draws [$];

    always #HALF_PERIOD clk = ~clk;

    combined_lcg_shuffle_rng_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    function automatic int to_s32(longint v);
        return int'(v[31:0]);
    endfunction

    // Schrage step in wide signed arithmetic, truncating division
    function automatic int lcg_step(int s, longint m, longint a, longint q, longint r);
        longint x;
        longint k;
        longint y;
        x = s;
        k = x / q;
        y = a * (x - k * q) - k * r;
        if (y < 0)
            y += m;
        return to_s32(y);
    endfunction

    function automatic int step_one(int s);
        return lcg_step(s, G1_MOD, G1_MUL, G1_QUO, G1_REM);
    endfunction

    function automatic int step_two(int s);
        return lcg_step(s, G2_MOD, G2_MUL, G2_QUO, G2_REM);
    endfunction

    function automatic void rng_seed(logic [30:0] s);
        gen_one = (s == '0) ? -1 : -int'({1'b0, s});
    endfunction

    // One combined step, reseeding the table first when generator one is not positive
    function automatic void rng_advance();
        longint slot;
        longint pos;
        if (gen_one <= 0)
        begin
            gen_two = gen_one;
            for (int n = TABLE_SIZE + 7; n >= 0; n--)
            begin
                gen_one = step_one(gen_one);
                if (n < TABLE_SIZE)
                    shuf_tab[n] = gen_one;
            end
            shuf_out = shuf_tab[0];
        end
        gen_one = step_one(gen_one);
        gen_two = step_two(gen_two);
        slot = longint'(shuf_out) / SLOT_DEN;
        if (slot < 0)
            slot = 0;
        if (slot >= TABLE_SIZE)
            slot = TABLE_SIZE - 1;
        pos = longint'(shuf_tab[slot]) - longint'(gen_two);
        shuf_tab[slot] = gen_one;
        if (pos < 1)
            pos += G_SPAN;
        shuf_out = to_s32(pos);
    endfunction

    function automatic void rng_modulate(int amount);
        gen_two = to_s32(longint'(gen_two) - longint'(amount));
        if (gen_two < 0)
            gen_two = to_s32(longint'(gen_two) + G2_MOD);
        rng_advance();
        gen_one = to_s32(longint'(gen_one) - longint'(amount));
        if (gen_one < 0)
            gen_one = to_s32(longint'(gen_one) + G1_MOD);
        rng_advance();
    endfunction

    function automatic result_t rng_draw(logic [31:0] modulus);
        result_t     r;
        logic [31:0] raw;
        rng_advance();
        raw = shuf_out;
        r.random_value  = raw[30:0];
        r.bounded_value = (modulus != '0) ? raw % modulus : '0;
        r.random_bit    = raw[0];
        return r;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.operation = ($urandom_range(99) < 25) ? OP_MODULATE : OP_DRAW;
        case ($urandom_range(7))
            0:       it.modulus = '0;
            1:       it.modulus = $urandom_range(16, 1);
            2:       it.modulus = 32'd1 << $urandom_range(31);
            3:       it.modulus = 32'hFFFFFFFF - $urandom_range(3);
            default: it.modulus = $urandom;
        endcase
        case ($urandom_range(5))
            0:       it.modulate_amount = '0;
            1:       it.modulate_amount = int'($urandom_range(200)) - 100;
            2:
            begin
                case ($urandom_range(3))
                    0:       it.modulate_amount = 32'h80000000;
                    1:       it.modulate_amount = 32'h7FFFFFFF;
                    2:       it.modulate_amount = 32'hFFFFFFFF;
                    default: it.modulate_amount = 32'h00000001;
                endcase
            end
            default: it.modulate_amount = $urandom;
        endcase
        return it;
    endfunction

    // Offer one item, hold it until the transfer, then advance the model
    task automatic send_item(item_t it, logic [1:0] pin, result_t pinned);
        int      gap_pct;
        result_t expected;
        gap_pct = (idle_mode == IDLE_SEND) ? 67 : (idle_mode == IDLE_BOTH) ? 33 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        if (it.operation == OP_MODULATE)
            rng_modulate(it.modulate_amount);
        else
        begin
            expected = rng_draw(it.modulus);
            if (pin == PIN_BOUNDED)
                expected.bounded_value = pinned.bounded_value;
            else if (pin == PIN_ALL)
                expected = pinned;
            pending_draws.push_back(expected);
        end
    endtask

    // Seed write only once the core is drained and any trailing modulate has finished
    task automatic write_seed(logic [30:0] s);
        item_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rng_seed(s);
    endtask

    // Result side: check each transfer, then pick the next ready level
    initial
    begin : result_side
        int      hold_left;
        bit      pressure_done;
        int      stall_pct;
        result_t expected;
        hold_left     = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (pending_draws.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    expected = pending_draws.pop_front();
                    if (result.random_value !== expected.random_value)
                    begin
                        $display("%0t: random_value expected %0d got %0d", $time,
                                 expected.random_value, result.random_value);
                        mismatches++;
                    end
                    if (result.bounded_value !== expected.bounded_value)
                    begin
                        $display("%0t: bounded_value expected %0d got %0d", $time,
                                 expected.bounded_value, result.bounded_value);
                        mismatches++;
                    end
                    if (result.random_bit !== expected.random_bit)
                    begin
                        $display("%0t: random_bit expected %0b got %0b", $time,
                                 expected.random_bit, result.random_bit);
                        mismatches++;
                    end
                end
            end
            stall_pct = (idle_mode == IDLE_RECV) ? 67 : (idle_mode == IDLE_BOTH) ? 33 : 0;
            // Long hold-off once, so the core fills and stops taking items
            if (idle_mode == IDLE_PRESSURE && !pressure_done && result_valid)
            begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles without any transfer
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        item_t       it;
        result_t     pinned;
        step_row_t   row;
        logic [30:0] seed_val;
        idle_mode_t  phase_mode [NUM_PHASES];
        phase_mode = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                       IDLE_PRESSURE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        gen_one  = -1;
        gen_two  = 0;
        shuf_out = 0;
        foreach (shuf_tab[n])
            shuf_tab[n] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset seed
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            it.operation       = row.op;
            it.modulus         = row.modulus;
            it.modulate_amount = row.amount;
            if (row.aim_zero)
                it.modulate_amount = step_one(gen_one);
            pinned = '{row.pin_value, row.pin_bounded, row.pin_value[0]};
            send_item(it, row.pin, pinned);
        end

        // Random phases: zero, largest and unit seed first, then random seeds
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       seed_val = '0;
                1:       seed_val = '1;
                2:       seed_val = 31'd1;
                default: seed_val = 31'($urandom);
            endcase
            idle_mode <= phase_mode[p];
            write_seed(seed_val);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                it = rand_item();
                // Now and then steer generator one onto zero
                if (it.operation == OP_MODULATE && gen_one > 0 && $urandom_range(49) == 0)
                    it.modulate_amount = step_one(gen_one);
                send_item(it, PIN_NONE, '0);
            end
        end

        item_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
